[sv/tfr_pkg.sv]
// shared constants and types for the toggled fade ramp generator
package tfr_pkg;

    localparam int unsigned TicksPerSecond = 1000;
    localparam logic [15:0] MinFadeMs      = 16'd20;
    localparam logic [9:0]  RampScale      = 10'd1000;
    localparam logic [6:0]  LsbCcOffset    = 7'd32;

    localparam logic [2:0] RegChannel  = 3'd0;
    localparam logic [2:0] RegCc       = 3'd1;
    localparam logic [2:0] RegLatch    = 3'd2;
    localparam logic [2:0] RegStart    = 3'd3;
    localparam logic [2:0] RegHold     = 3'd4;
    localparam logic [2:0] RegEnd      = 3'd5;
    localparam logic [2:0] RegFadeIn   = 3'd6;
    localparam logic [2:0] RegFadeOut  = 3'd7;

    localparam logic [1:0] PhaseIn      = 2'd0;
    localparam logic [1:0] PhaseFall    = 2'd1;
    localparam logic [1:0] PhaseRise    = 2'd2;

    // which step register a finished division goes to
    typedef enum logic [1:0] {
        t_DST_NONE = 2'd0,
        t_DST_RISE = 2'd1,
        t_DST_FALL = 2'd2
    } t_dst;

    // controller to datapath commands
    typedef struct packed {
        logic div_start;   // latch operands and start the divider
        logic div_rise;    // operands from start/hold for rise step
        logic div_cfgfall; // operands from hold/end for fall step
        logic word_apply;  // apply accepted word to state
        logic out_load;    // load output register
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic div_busy;
        logic need_rise;
        logic need_fall;
        logic word_div;    // accepted word needs a fall step division
        logic word_has_out;
    } t_sts;

endpackage

[sv/tfr_ctrl.sv]
// controller sequencing config reloads, word processing and divisions
module tfr_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic          i_valid,
    output logic          o_stall,
    input  logic          i_out_busy,
    input  tfr_pkg::t_sts i_sts,
    output tfr_pkg::t_cmd o_cmd
);
    import tfr_pkg::*;

    typedef enum logic [4:0] {
        t_ST_IDLE   = 5'b00001,
        t_ST_RISE   = 5'b00010,
        t_ST_FALL   = 5'b00100,
        t_ST_WDIV   = 5'b01000,
        t_ST_WAIT   = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic   r_pend, n_pend;     // config written, steps need reload

    always_comb begin
        n_state = r_state;
        n_pend  = r_pend | i_cfg_we;
        o_cmd   = '0;
        o_stall = 1'b1;
        case (r_state)
            t_ST_IDLE: begin
                if (r_pend && !i_cfg_we) begin
                    n_pend = 1'b0;
                    if (i_sts.need_rise) begin
                        o_cmd.div_start = 1'b1;
                        o_cmd.div_rise  = 1'b1;
                        n_state = t_ST_RISE;
                    end else if (i_sts.need_fall) begin
                        o_cmd.div_start   = 1'b1;
                        o_cmd.div_cfgfall = 1'b1;
                        n_state = t_ST_FALL;
                    end
                end else if (!r_pend && !i_cfg_we && !i_out_busy) begin
                    o_stall = 1'b0;
                    if (i_valid) begin
                        o_cmd.word_apply = 1'b1;
                        if (i_sts.word_div) begin
                            o_cmd.div_start = 1'b1;
                            n_state = t_ST_WDIV;
                        end else begin
                            o_cmd.out_load = i_sts.word_has_out;
                        end
                    end
                end
            end
            t_ST_RISE: begin
                if (!i_sts.div_busy) begin
                    if (i_sts.need_fall) begin
                        o_cmd.div_start   = 1'b1;
                        o_cmd.div_cfgfall = 1'b1;
                        n_state = t_ST_FALL;
                    end else begin
                        n_state = t_ST_IDLE;
                    end
                end
            end
            t_ST_FALL: begin
                if (!i_sts.div_busy) n_state = t_ST_IDLE;
            end
            t_ST_WDIV: begin
                if (!i_sts.div_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state = t_ST_IDLE;
                end
            end
            t_ST_WAIT: begin
                n_state = t_ST_IDLE;
            end
            default: n_state = t_ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= t_ST_IDLE;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
        end
    end

endmodule

[sv/tfr_div.sv]
// restoring 16-bit divider, one quotient bit per cycle
module tfr_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [15:0] i_num,
    input  logic [15:0] i_den,
    output logic        o_busy,
    output logic [15:0] o_quot
);
    logic [4:0]  r_cnt;
    logic [15:0] r_q, r_d;
    logic [16:0] r_rem;
    logic [16:0] w_sh;
    logic [16:0] w_sub;

    assign w_sh  = {r_rem[15:0], r_q[15]};
    assign w_sub = w_sh - {1'b0, r_d};
    assign o_busy = (r_cnt != 5'd0);
    assign o_quot = r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 5'd0;
        end else if (i_start) begin
            r_cnt <= 5'd16;
        end else if (o_busy) begin
            r_cnt <= r_cnt - 5'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_d   <= i_den;
            r_rem <= '0;
        end else if (o_busy) begin
            if (!w_sub[16]) begin
                r_rem <= w_sub;
                r_q   <= {r_q[14:0], 1'b1};
            end else begin
                r_rem <= w_sh;
                r_q   <= {r_q[14:0], 1'b0};
            end
        end
    end

endmodule

[sv/tfr_dp.sv]
// datapath: config registers, ramp state, step math and output register
module tfr_dp #(
    parameter int unsigned TICKS_PER_SECOND = tfr_pkg::TicksPerSecond
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [2:0]    i_cfg_idx,
    input  logic [15:0]   i_cfg_data,
    input  logic          i_kind,
    input  logic [15:0]   i_param_value,
    input  tfr_pkg::t_cmd i_cmd,
    output tfr_pkg::t_sts o_sts,
    output logic          o_valid,
    input  logic          i_stall,
    output logic          o_out_busy,
    output logic          o_command_valid,
    output logic          o_led_on,
    output logic [3:0]    o_out_channel,
    output logic [6:0]    o_msb_controller,
    output logic [6:0]    o_msb_data,
    output logic [6:0]    o_lsb_controller,
    output logic [6:0]    o_lsb_data
);
    import tfr_pkg::*;

    localparam logic [15:0] Tps = 16'(TICKS_PER_SECOND);

    logic [3:0]  r_chan;
    logic [6:0]  r_cc;
    logic        r_latch;
    logic [15:0] r_start, r_hold, r_end, r_fin, r_fout;
    logic [15:0] r_last, r_level, r_rstep, r_fstep;
    logic        r_tog, r_ract, r_fact;
    logic [1:0]  r_phase;
    t_dst        r_dst;

    // step operands captured at the last config write that called for a reload
    logic        r_rsnap, r_fsnap;
    logic [15:0] r_rnum, r_rden, r_fnum, r_fden;

    // pending output values
    logic        r_o_valid;
    logic        r_o_cmd, r_o_led;
    logic [15:0] r_o_lvl;

    logic [15:0] w_num_mul;
    logic        w_div_busy;
    logic [15:0] w_quot, w_num, w_den;
    logic [15:0] w_dist;
    logic        w_fin_ok, w_fout_ok;

    assign w_fin_ok  = r_fin  >= MinFadeMs;
    assign w_fout_ok = r_fout >= MinFadeMs;

    // config as it stands after the current write
    logic [15:0] w_c_start, w_c_hold, w_c_end, w_c_fin, w_c_fout;
    logic [15:0] w_c_rdist, w_c_fdist;
    logic        w_c_rneed, w_c_fneed;
    assign w_c_start = (i_cfg_we && i_cfg_idx == RegStart) ? {2'b00, i_cfg_data[13:0]} : r_start;
    assign w_c_hold  = (i_cfg_we && i_cfg_idx == RegHold)  ? {2'b00, i_cfg_data[13:0]} : r_hold;
    assign w_c_end   = (i_cfg_we && i_cfg_idx == RegEnd)   ? {2'b00, i_cfg_data[13:0]} : r_end;
    assign w_c_fin   = (i_cfg_we && i_cfg_idx == RegFadeIn)  ? i_cfg_data : r_fin;
    assign w_c_fout  = (i_cfg_we && i_cfg_idx == RegFadeOut) ? i_cfg_data : r_fout;
    assign w_c_rneed = (w_c_fin >= MinFadeMs) && (w_c_start != w_c_hold);
    assign w_c_fneed = (w_c_fout >= MinFadeMs) && (w_c_end != w_c_hold);
    assign w_c_rdist = (w_c_start < w_c_hold) ? (w_c_hold - w_c_start) : (w_c_start - w_c_hold);
    assign w_c_fdist = (w_c_end < w_c_hold) ? (w_c_hold - w_c_end) : (w_c_end - w_c_hold);

    assign o_sts.div_busy  = w_div_busy;
    assign o_sts.need_rise = r_rsnap;
    assign o_sts.need_fall = r_fsnap;

    // word decode
    logic w_changed, w_tog_n, w_take;
    always_comb begin
        w_take  = (i_param_value != r_last);
        w_tog_n = r_tog;
        w_changed = 1'b0;
        if (r_latch) begin
            if (i_param_value != 16'd0) begin
                w_tog_n = ~r_tog;
                w_changed = 1'b1;
            end
        end else begin
            w_tog_n = (i_param_value != 16'd0);
            w_changed = 1'b1;
        end
    end

    logic w_modal, w_fdn, w_fup;
    assign w_modal = w_fout_ok && (r_end != r_hold);
    assign w_fdn   = (r_end < r_level) && (r_phase != PhaseFall);
    assign w_fup   = (r_end > r_level) && (r_phase != PhaseRise);

    assign o_sts.word_div = i_kind && w_take && w_changed && !w_tog_n && w_modal
                            && (w_fdn || w_fup);

    // tick evaluation
    logic        w_t_out, w_t_ract, w_t_fact;
    logic [15:0] w_t_lvl, w_t_send, w_add, w_sub_r, w_sub_f, w_add_f;
    always_comb begin
        w_add   = r_level + r_rstep;
        w_sub_r = r_level - r_rstep;
        w_sub_f = r_level - r_fstep;
        w_add_f = r_level + r_fstep;
        w_t_out  = 1'b0;
        w_t_lvl  = r_level;
        w_t_send = r_level;
        w_t_ract = r_ract;
        w_t_fact = r_fact;
        if (r_phase == PhaseIn) begin
            if (r_ract) begin
                if (!w_fin_ok) begin
                    w_t_out = 1'b1; w_t_lvl = r_hold; w_t_send = r_hold;
                    w_t_ract = 1'b0;
                end else if (r_start < r_hold) begin
                    w_t_out = 1'b1;
                    if (w_add < r_hold) begin
                        w_t_lvl = w_add; w_t_send = w_add;
                    end else begin
                        w_t_lvl = r_hold; w_t_send = r_hold; w_t_ract = 1'b0;
                    end
                end else if (r_start > r_hold) begin
                    w_t_out = 1'b1;
                    if (w_sub_r > r_hold && r_rstep < w_sub_r) begin
                        w_t_lvl = w_sub_r; w_t_send = w_sub_r;
                    end else begin
                        w_t_lvl = r_hold; w_t_send = r_hold; w_t_ract = 1'b0;
                    end
                end
            end
        end else if (r_phase == PhaseFall || r_phase == PhaseRise) begin
            if (r_fact) begin
                w_t_out = 1'b1;
                w_t_send = r_end;
                if (!w_fout_ok) begin
                    w_t_fact = 1'b0;
                end else if (r_phase == PhaseFall) begin
                    w_t_lvl = w_sub_f;
                    if (w_sub_f > r_end && r_fstep < w_sub_f) w_t_send = w_sub_f;
                    else w_t_fact = 1'b0;
                end else begin
                    w_t_lvl = w_add_f;
                    if (w_add_f < r_end) w_t_send = w_add_f;
                    else w_t_fact = 1'b0;
                end
            end
        end
    end

    assign o_sts.word_has_out = i_kind ? w_take : w_t_out;

    // divider operands
    assign w_dist    = w_fdn ? (r_level - r_end) : (r_end - r_level);
    assign w_num_mul = 16'(w_dist * RampScale);
    always_comb begin
        if (i_cmd.div_rise) begin
            w_num = r_rnum;
            w_den = r_rden;
        end else if (i_cmd.div_cfgfall) begin
            w_num = r_fnum;
            w_den = r_fden;
        end else begin
            w_num = w_num_mul;
            w_den = 16'(Tps * r_fout);
        end
    end

    // a zero divisor yields all ones from the divider
    tfr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_busy  (w_div_busy),
        .o_quot  (w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chan <= '0; r_cc <= '0; r_latch <= 1'b0;
            r_start <= '0; r_hold <= '0; r_end <= '0; r_fin <= '0; r_fout <= '0;
            r_last <= '0; r_level <= '0; r_rstep <= '0; r_fstep <= '0;
            r_tog <= 1'b0; r_ract <= 1'b0; r_fact <= 1'b0; r_phase <= PhaseIn;
            r_dst <= t_DST_NONE;
            r_rsnap <= 1'b0; r_fsnap <= 1'b0;
            r_rnum <= '0; r_rden <= '0; r_fnum <= '0; r_fden <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    RegChannel: r_chan  <= i_cfg_data[3:0];
                    RegCc:      r_cc    <= i_cfg_data[6:0];
                    RegLatch:   r_latch <= i_cfg_data[0];
                    RegStart:   r_start <= {2'b00, i_cfg_data[13:0]};
                    RegHold:    r_hold  <= {2'b00, i_cfg_data[13:0]};
                    RegEnd:     r_end   <= {2'b00, i_cfg_data[13:0]};
                    RegFadeIn:  r_fin   <= i_cfg_data;
                    RegFadeOut: r_fout  <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cfg_we && w_c_rneed) begin
                r_rsnap <= 1'b1;
                r_rnum  <= 16'(w_c_rdist * RampScale);
                r_rden  <= 16'(Tps * w_c_fin);
            end else if (i_cmd.div_start && i_cmd.div_rise) begin
                r_rsnap <= 1'b0;
            end
            if (i_cfg_we && w_c_fneed) begin
                r_fsnap <= 1'b1;
                r_fnum  <= 16'(w_c_fdist * RampScale);
                r_fden  <= 16'(Tps * w_c_fout);
            end else if (i_cmd.div_start && i_cmd.div_cfgfall) begin
                r_fsnap <= 1'b0;
            end
            if (i_cmd.div_start)
                r_dst <= i_cmd.div_rise ? t_DST_RISE : t_DST_FALL;
            else if (r_dst != t_DST_NONE && !w_div_busy)
                r_dst <= t_DST_NONE;
            if (r_dst != t_DST_NONE && !w_div_busy) begin
                if (r_dst == t_DST_RISE) r_rstep <= w_quot;
                else r_fstep <= w_quot;
            end
            if (i_cmd.word_apply) begin
                if (i_kind) begin
                    if (w_take) begin
                        r_last <= i_param_value;
                        r_tog  <= w_tog_n;
                        if (w_changed) begin
                            if (w_tog_n) begin
                                r_phase <= PhaseIn; r_ract <= 1'b1; r_fact <= 1'b0;
                                r_level <= r_start;
                            end else begin
                                if (w_modal) begin
                                    if (w_fdn) r_phase <= PhaseFall;
                                    else if (w_fup) r_phase <= PhaseRise;
                                end else begin
                                    r_phase <= PhaseFall;
                                end
                                r_ract <= 1'b0; r_fact <= 1'b1;
                            end
                        end
                    end
                    r_o_cmd <= 1'b0;
                    r_o_led <= w_tog_n;
                end else begin
                    r_level <= w_t_lvl;
                    r_ract  <= w_t_ract;
                    r_fact  <= w_t_fact;
                    r_o_cmd <= 1'b1;
                    r_o_led <= r_tog;
                    r_o_lvl <= w_t_send;
                end
            end
            if (i_cmd.out_load) r_o_valid <= 1'b1;
            else if (r_o_valid && !i_stall) r_o_valid <= 1'b0;
        end
    end

    assign o_out_busy       = r_o_valid;
    assign o_valid          = r_o_valid;
    assign o_command_valid  = r_o_cmd;
    assign o_led_on         = r_o_led;
    assign o_out_channel    = r_o_cmd ? r_chan : 4'd0;
    assign o_msb_controller = r_o_cmd ? r_cc : 7'd0;
    assign o_msb_data       = r_o_cmd ? r_o_lvl[13:7] : 7'd0;
    assign o_lsb_controller = r_o_cmd ? 7'(r_cc + LsbCcOffset) : 7'd0;
    assign o_lsb_data       = r_o_cmd ? r_o_lvl[6:0] : 7'd0;

endmodule

[sv/toggled_fade_ramp_generator.sv]
// top level of the toggled fade ramp generator
// usage:
//   input channel: i_valid / o_stall carry one word, i_kind selects a tick (0)
//   or a new parameter value (1, in i_param_value).
//   output channel: o_valid / i_stall carry a result word: a control change
//   pair with the 14-bit level split in two 7-bit halves, or an LED update.
//   a word gives zero or one result, valid in the cycle after acceptance;
//   a switch-off that needs a new fall step waits for the
//   serial divider (one quotient bit per cycle).
//   no new word is accepted while a division for the last one is running.
//   config writes trigger a reload of the step sizes that the new config needs,
//   which runs after the last write and during which no word is accepted.
//   a new word is accepted only when the output register is empty, so a
//   stalled receiver holds the input stalled as well.
//   reset clears the control and ramp state, config registers to zero, no result pending.
module toggled_fade_ramp_generator #(
    parameter int unsigned TICKS_PER_SECOND = tfr_pkg::TicksPerSecond
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_kind,
    input  logic [15:0] i_param_value,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_command_valid,
    output logic        o_led_on,
    output logic [3:0]  o_out_channel,
    output logic [6:0]  o_msb_controller,
    output logic [6:0]  o_msb_data,
    output logic [6:0]  o_lsb_controller,
    output logic [6:0]  o_lsb_data
);
    import tfr_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;
    logic w_out_busy;

    tfr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_out_busy (w_out_busy),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    tfr_dp #(.TICKS_PER_SECOND(TICKS_PER_SECOND)) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_kind           (i_kind),
        .i_param_value    (i_param_value),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_out_busy       (w_out_busy),
        .o_command_valid  (o_command_valid),
        .o_led_on         (o_led_on),
        .o_out_channel    (o_out_channel),
        .o_msb_controller (o_msb_controller),
        .o_msb_data       (o_msb_data),
        .o_lsb_controller (o_lsb_controller),
        .o_lsb_data       (o_lsb_data)
    );

endmodule

[test/toggled_fade_ramp_generator_tb.sv]
// self-checking testbench for the toggled fade ramp generator
module toggled_fade_ramp_generator_tb;
    import tfr_pkg::*;

    typedef struct packed {
        logic       cmd;
        logic       led;
        logic [3:0] chan;
        logic [6:0] msb_cc;
        logic [6:0] msb_data;
        logic [6:0] lsb_cc;
        logic [6:0] lsb_data;
    } ramp_word_t;

    class fade_scoreboard;
        bit [3:0]   chan;
        bit [6:0]   cc;
        bit         latch;
        bit [15:0]  lvl_start, lvl_hold, lvl_end, ms_in, ms_out;
        bit [15:0]  last_param, level, rise_step, fall_step;
        bit         toggle, rising, falling;
        bit [1:0]   phase;
        ramp_word_t pending[$];
        int         errors;

        function bit [15:0] divisor(bit [15:0] ms);
            return 16'(32'(TicksPerSecond) * 32'(ms));
        endfunction

        function bit [15:0] ramp_step(bit [15:0] hi, bit [15:0] lo, bit [15:0] d);
            bit [15:0] diff;
            bit [15:0] num;
            diff = hi - lo;
            num = 16'(32'(diff) * 32'd1000);
            if (d == 0) return 16'hFFFF;
            return num / d;
        endfunction

        function void reload();
            if (ms_in >= MinFadeMs) begin
                if (lvl_start < lvl_hold)
                    rise_step = ramp_step(lvl_hold, lvl_start, divisor(ms_in));
                else if (lvl_start > lvl_hold)
                    rise_step = ramp_step(lvl_start, lvl_hold, divisor(ms_in));
            end
            if (ms_out >= MinFadeMs) begin
                if (lvl_end < lvl_hold)
                    fall_step = ramp_step(lvl_hold, lvl_end, divisor(ms_out));
                else if (lvl_end > lvl_hold)
                    fall_step = ramp_step(lvl_end, lvl_hold, divisor(ms_out));
            end
        endfunction

        function void write_reg(logic [2:0] idx, logic [15:0] d);
            case (idx)
                RegChannel: chan = d[3:0];
                RegCc:      cc = d[6:0];
                RegLatch:   latch = d[0];
                RegStart:   lvl_start = {2'b0, d[13:0]};
                RegHold:    lvl_hold = {2'b0, d[13:0]};
                RegEnd:     lvl_end = {2'b0, d[13:0]};
                RegFadeIn:  ms_in = d;
                RegFadeOut: ms_out = d;
                default: ;
            endcase
            reload();
        endfunction

        function void push_level(bit [15:0] v);
            ramp_word_t r;
            r.cmd = 1;
            r.led = toggle;
            r.chan = chan;
            r.msb_cc = cc;
            r.msb_data = v[13:7];
            r.lsb_cc = cc + LsbCcOffset;
            r.lsb_data = v[6:0];
            pending.push_back(r);
        endfunction

        function void note_input(bit kind, bit [15:0] v);
            bit changed;
            ramp_word_t r;
            if (kind) begin
                if (v == last_param) return;
                last_param = v;
                changed = 0;
                if (latch) begin
                    if (v != 0) begin
                        toggle = !toggle;
                        changed = 1;
                    end
                end else begin
                    toggle = (v != 0);
                    changed = 1;
                end
                if (changed) begin
                    if (toggle) begin
                        phase = PhaseIn;
                        rising = 1;
                        falling = 0;
                        level = lvl_start;
                    end else begin
                        if (ms_out >= MinFadeMs && lvl_end != lvl_hold) begin
                            if (lvl_end < level && phase != PhaseFall) begin
                                fall_step = ramp_step(level, lvl_end, divisor(ms_out));
                                phase = PhaseFall;
                            end
                            if (lvl_end > level && phase != PhaseRise) begin
                                fall_step = ramp_step(lvl_end, level, divisor(ms_out));
                                phase = PhaseRise;
                            end
                        end else begin
                            phase = PhaseFall;
                        end
                        rising = 0;
                        falling = 1;
                    end
                end
                r = '0;
                r.led = toggle;
                pending.push_back(r);
                return;
            end
            if (phase == PhaseIn) begin
                if (!rising) return;
                if (ms_in < MinFadeMs) begin
                    level = lvl_hold;
                    rising = 0;
                    push_level(lvl_hold);
                end else if (lvl_start < lvl_hold) begin
                    level = level + rise_step;
                    if (level < lvl_hold) push_level(level);
                    else begin
                        level = lvl_hold;
                        rising = 0;
                        push_level(lvl_hold);
                    end
                end else if (lvl_start > lvl_hold) begin
                    level = level - rise_step;
                    if (level > lvl_hold && rise_step < level) push_level(level);
                    else begin
                        level = lvl_hold;
                        rising = 0;
                        push_level(lvl_hold);
                    end
                end
            end else if (phase == PhaseFall || phase == PhaseRise) begin
                if (!falling) return;
                if (ms_out < MinFadeMs) begin
                    falling = 0;
                    push_level(lvl_end);
                    return;
                end
                if (phase == PhaseFall) begin
                    level = level - fall_step;
                    if (level > lvl_end && fall_step < level) begin
                        push_level(level);
                        return;
                    end
                end else begin
                    level = level + fall_step;
                    if (level < lvl_end) begin
                        push_level(level);
                        return;
                    end
                end
                falling = 0;
                push_level(lvl_end);
            end
        endfunction

        function void check_result(ramp_word_t got);
            ramp_word_t exp;
            if (pending.size() == 0) begin
                $error("unexpected result word %h", got);
                errors++;
                return;
            end
            exp = pending.pop_front();
            if (got.cmd !== exp.cmd) begin
                $error("command_valid exp %0d got %0d", exp.cmd, got.cmd); errors++;
            end
            if (got.led !== exp.led) begin
                $error("led_on exp %0d got %0d", exp.led, got.led); errors++;
            end
            if (got.chan !== exp.chan) begin
                $error("out_channel exp %0d got %0d", exp.chan, got.chan); errors++;
            end
            if (got.msb_cc !== exp.msb_cc) begin
                $error("msb_controller exp %0d got %0d", exp.msb_cc, got.msb_cc); errors++;
            end
            if (got.msb_data !== exp.msb_data) begin
                $error("msb_data exp %0d got %0d", exp.msb_data, got.msb_data); errors++;
            end
            if (got.lsb_cc !== exp.lsb_cc) begin
                $error("lsb_controller exp %0d got %0d", exp.lsb_cc, got.lsb_cc); errors++;
            end
            if (got.lsb_data !== exp.lsb_data) begin
                $error("lsb_data exp %0d got %0d", exp.lsb_data, got.lsb_data); errors++;
            end
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_cfg_we = 0;
    logic [2:0]  i_cfg_idx = '0;
    logic [15:0] i_cfg_data = '0;
    logic        i_valid = 0;
    logic        o_stall;
    logic        i_kind = 0;
    logic [15:0] i_param_value = '0;
    logic        o_valid;
    logic        i_stall = 0;
    logic        o_command_valid, o_led_on;
    logic [3:0]  o_out_channel;
    logic [6:0]  o_msb_controller, o_msb_data, o_lsb_controller, o_lsb_data;

    fade_scoreboard ramp_sb = new();
    bit  calm;
    bit  running;
    int  hold_cycles;

    toggled_fade_ramp_generator i_dut (.*);

    always begin
        #4 i_clk = 1;
        #4 i_clk = 0;
    end

    initial begin
        #16000000;
        $display("toggled_fade_ramp_generator_tb failed");
        $finish;
    end

    // receiver: check accepted results and drive stall
    always @(posedge i_clk) begin
        if (running) begin
            if (o_valid && !i_stall)
                ramp_sb.check_result({o_command_valid, o_led_on, o_out_channel,
                    o_msb_controller, o_msb_data, o_lsb_controller, o_lsb_data});
            if (hold_cycles > 0) begin
                hold_cycles--;
                i_stall <= 1;
            end else begin
                i_stall <= !calm && ($urandom_range(99) < 17);
            end
        end
    end

    task automatic send_word(bit kind, logic [15:0] v);
        if (!calm && $urandom_range(99) < 17) begin
            i_valid <= 0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_valid <= 1;
        i_kind <= kind;
        i_param_value <= v;
        do @(posedge i_clk); while (o_stall);
        ramp_sb.note_input(kind, v);
    endtask

    task automatic drain();
        i_valid <= 0;
        @(posedge i_clk);
        while (ramp_sb.pending.size() != 0) @(posedge i_clk);
        repeat (45) @(posedge i_clk);
    endtask

    task automatic write_regs(logic [15:0] vals[8]);
        drain();
        for (int i = 0; i < 8; i++) begin
            i_cfg_we <= 1;
            i_cfg_idx <= 3'(i);
            i_cfg_data <= vals[i];
            @(posedge i_clk);
            ramp_sb.write_reg(3'(i), vals[i]);
        end
        i_cfg_we <= 0;
    endtask

    function automatic logic [15:0] pick_ms();
        case ($urandom_range(5))
            0: return 16'($urandom_range(19));
            1: return 16'd8192;
            2: return 16'hFFFF;
            3: return 16'($urandom);
            default: return 16'($urandom_range(20, 300));
        endcase
    endfunction

    function automatic logic [15:0] pick_param();
        case ($urandom_range(9))
            0, 1, 2: return 16'd0;
            3, 4: return ramp_sb.last_param;
            5: return 16'hFFFF;
            6: return 16'(1 << $urandom_range(15));
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        logic [15:0] cfg[8];
        logic [15:0] bits;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;
        running = 1;
        @(posedge i_clk);

        // directed: jump fades at reset values, then a real ramp
        send_word(1, 16'h0000);
        send_word(1, 16'hFFFF);
        send_word(0, 0);
        send_word(1, 16'hFFFF);
        send_word(1, 16'h0000);
        send_word(0, 0);
        cfg = '{16'd15, 16'd95, 16'd0, 16'd100, 16'd16383, 16'd0, 16'd50, 16'd30};
        write_regs(cfg);
        send_word(1, 16'h0001);
        repeat (5) send_word(0, 0);
        send_word(1, 16'h0000);
        repeat (5) send_word(0, 0);
        // zero divisor on both fades, descending fade-in
        cfg = '{16'd0, 16'd0, 16'd1, 16'd16383, 16'd0, 16'd16383, 16'd8192, 16'd8192};
        write_regs(cfg);
        send_word(1, 16'h8000);
        send_word(0, 0);
        send_word(1, 16'h8000);
        send_word(1, 16'h4000);
        repeat (2) send_word(0, 0);

        for (int ph = 0; ph < 7; ph++) begin
            bits = (ph == 2) ? 16'hFFFF : 16'($urandom);
            cfg[0] = 16'($urandom_range(15));
            cfg[1] = 16'($urandom_range(95));
            cfg[2] = 16'($urandom_range(1));
            cfg[3] = 16'($urandom_range(16383));
            cfg[4] = ($urandom_range(3) == 0) ? cfg[3] : 16'($urandom_range(16383));
            cfg[5] = ($urandom_range(3) == 0) ? cfg[4] : 16'($urandom_range(16383));
            cfg[6] = pick_ms();
            cfg[7] = pick_ms();
            if (ph == 0) cfg = '{16'd15, 16'd95, 16'd0, 16'd0, 16'd16383, 16'd0,
                                 16'd20, 16'd19};
            if (ph == 1) cfg = '{16'd0, 16'd0, 16'd1, 16'd16383, 16'd0, 16'd16383,
                                 16'hFFFF, 16'd20};
            if (ph == 2) cfg[2] = bits;
            write_regs(cfg);
            calm = (ph == 3);
            for (int n = 0; n < 250; n++) begin
                if (ph == 4 && n == 100) hold_cycles = 300;
                if (ph == 5 && n == 120) drain();
                if ($urandom_range(99) < 20) send_word(1, pick_param());
                else send_word(0, 16'($urandom));
            end
        end
        calm = 0;
        drain();
        if (ramp_sb.errors == 0) begin
            $display("toggled_fade_ramp_generator_tb passed");
        end else begin
            $display("toggled_fade_ramp_generator_tb failed");
        end
        $finish;
    end
endmodule

[filelist.f]
sv/tfr_pkg.sv
sv/tfr_ctrl.sv
sv/tfr_div.sv
sv/tfr_dp.sv
sv/toggled_fade_ramp_generator.sv
test/toggled_fade_ramp_generator_tb.sv
